// ===== hdl/smsr_pkg.sv =====
// ----------------------------------------------------------------------------
// smsr_pkg : shared types and constants of the motor speed regulator
// Controller states, command/status structs, register indexes, helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package smsr_pkg;

  localparam int WinDepth  = 5;
  localparam int WinIdxW   = (WinDepth > 1) ? $clog2(WinDepth) : 1;
  localparam int WinCntW   = $clog2(WinDepth + 1);
  localparam int SumW      = 20 + WinCntW;
  localparam int NumW      = 52;  // |dcount| * 960000 < 2^52
  localparam int DenW      = 45;  // ppt(13) * dt(32)
  localparam int QuoW      = 21;  // quotient width before saturation
  localparam logic [19:0] SpeedMax = 20'hFFFFF;
  localparam logic [19:0] RpmScale = 20'd960000;

  localparam logic [2:0] RegTarget   = 3'd0;
  localparam logic [2:0] RegFineLim  = 3'd1;
  localparam logic [2:0] RegTol      = 3'd2;
  localparam logic [2:0] RegSettle   = 3'd3;
  localparam logic [2:0] RegInterval = 3'd4;
  localparam logic [2:0] RegPpt      = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MEAS_CHK,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_SUM,
    ST_AVG,
    ST_REG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic do_start;
    logic mul;
    logic div_init;
    logic div_step;
    logic store;
    logic sum_init;
    logic sum_step;
    logic avg_init;
    logic avg_step;
    logic avg_done;
    logic regulate;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic meas_due;
    logic div_last;
    logic sum_last;
    logic avg_last;
  } sts_t;

  // tenths/10 as (tenths*205)>>11, exact below 1029; pct*75/100 is pct*3/4
  function automatic logic [7:0] duty_to_pwm(input logic [9:0] tenths);
    logic [17:0] scaled;
    logic [6:0]  pct;
    logic [8:0]  pct3;
    begin
      scaled = 18'(tenths) * 18'd205;
      pct    = scaled[17:11];
      pct3   = 9'(pct) * 9'd3;
      duty_to_pwm = 8'd180 + {1'b0, pct3[8:2]};
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/stepped_motor_speed_regulator.sv =====
// ----------------------------------------------------------------------------
// stepped_motor_speed_regulator : encoder speed loop with banded duty steps
// Start beat: start, then output. Control beat: measurement check, then, if
// a measurement is due, speed divide, window sum of 1 to 5 samples at one a
// cycle and average divide; then regulate and output. One beat at a
// time; a result held off by out_tready delays the next accept by its stall.
// Reset (rst_n, synchronous, active low) clears sequencer, output valid and
// regulator state, loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module stepped_motor_speed_regulator import smsr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // mode[0], now_ms[32:1], encoder_count[64:33]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // pwm_duty[7:0], duty_tenths[17:8],
                                       // measured_speed[37:18], is_stable[38]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [17:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic busy, in_fire, out_free;
  logic [7:0]  pwm;
  logic [9:0]  duty;
  logic [19:0] avg;
  logic        stable;
  logic        ovalid_r;
  logic [38:0] odata_r;

  // result register: frees the sequencer once the previous beat is taken
  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;

  smsr_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_mode(in_tdata[0]), .out_free, .sts, .busy, .cmd
  );

  smsr_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_now(in_tdata[32:1]), .in_count(in_tdata[64:33]),
    .cfg_we, .cfg_idx, .cfg_wdata,
    .pwm_level(pwm), .duty_level(duty), .avg_speed(avg), .stable
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.out_load) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
    if (cmd.out_load) odata_r <= {stable, avg, duty, pwm};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, odata_r};

  // one beat in flight at most
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> busy)
    else $error("sequencer not busy after accept");
  a_duty: assert property (@(posedge clk) disable iff (!rst_n) duty <= 10'd1000)
    else $error("duty out of range");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("result lost");

endmodule
`default_nettype wire

// ===== hdl/smsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// smsr_ctrl : sequencer of the regulator
// Walks start, or measure, divide, window sum, average and regulate steps, then output, per beat.
// ----------------------------------------------------------------------------
`default_nettype none
module smsr_ctrl import smsr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic in_mode,
  input  wire logic out_free,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = in_mode ? ST_START : ST_MEAS_CHK;
      ST_START:    state_nxt = ST_OUT;
      ST_MEAS_CHK: state_nxt = sts.meas_due ? ST_MUL : ST_REG;
      ST_MUL:      state_nxt = ST_DIV;
      ST_DIV:      if (sts.div_last) state_nxt = ST_STORE;
      ST_STORE:    state_nxt = ST_SUM;
      ST_SUM:      if (sts.sum_last) state_nxt = ST_AVG;
      ST_AVG:      if (sts.avg_last) state_nxt = ST_REG;
      ST_REG:      state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    busy     = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:     cmd.capture  = in_fire;
      ST_START:    cmd.do_start = 1'b1;
      ST_MEAS_CHK: cmd.mul      = sts.meas_due;
      ST_MUL:      cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_STORE: begin
        cmd.store    = 1'b1;
        cmd.sum_init = 1'b1;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        cmd.avg_init = sts.sum_last;
      end
      ST_AVG: begin
        cmd.avg_step = 1'b1;
        cmd.avg_done = sts.avg_last;
      end
      ST_REG:      cmd.regulate = 1'b1;
      ST_OUT:      cmd.out_load = out_free;
      default:     cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/smsr_dp.sv =====
// ----------------------------------------------------------------------------
// smsr_dp : regulator datapath
// Holds state, the shared shift-subtract divider, speed window and duty logic.
// ----------------------------------------------------------------------------
`default_nettype none
module smsr_dp import smsr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [31:0] in_now,
  input  wire logic [31:0] in_count,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [17:0] cfg_wdata,
  output logic [7:0]       pwm_level,
  output logic [9:0]       duty_level,
  output logic [19:0]      avg_speed,
  output logic             stable
);

  // configuration
  logic [17:0] target_r;
  logic [9:0]  fine_r;
  logic [13:0] tol_r;
  logic [15:0] settle_r, ivl_r;
  logic [12:0] ppt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      fine_r   <= 10'd50;
      tol_r    <= 14'd80;
      settle_r <= 16'd1000;
      ivl_r    <= 16'd100;
      ppt_r    <= 13'd12;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegTarget:   target_r <= cfg_wdata;
        RegFineLim:  fine_r   <= cfg_wdata[9:0];
        RegTol:      tol_r    <= cfg_wdata[13:0];
        RegSettle:   settle_r <= cfg_wdata[15:0];
        RegInterval: ivl_r    <= cfg_wdata[15:0];
        RegPpt:      ppt_r    <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [31:0] now_r, cnt_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r <= in_now;
      cnt_r <= in_count;
    end
  end

  // regulator state
  logic [31:0] last_meas_r, last_cnt_r, last_adj_r, settle_start_r;
  logic [19:0] win_r [WinDepth];
  logic [WinIdxW-1:0] slot_r;
  logic        filled_r, stable_r;
  logic [19:0] avg_r;
  logic [9:0]  duty_r;
  logic [7:0]  pwm_r;

  // measurement
  logic [31:0] dt, dcnt, dabs;
  logic [15:0] ivl_eff;
  logic [12:0] ppt_eff;
  assign dt      = now_r - last_meas_r;
  assign ivl_eff = (ivl_r == '0) ? 16'd1 : ivl_r;
  assign ppt_eff = (ppt_r == '0) ? 13'd1 : ppt_r;
  assign dcnt    = cnt_r - last_cnt_r;
  assign dabs    = dcnt[31] ? (~dcnt + 32'd1) : dcnt;
  assign sts.meas_due = (dt >= 32'(ivl_eff));

  // restoring divider shared by speed and average: one quotient bit a cycle
  logic [NumW-1:0] num_r;
  logic [DenW-1:0] den_r;
  logic [DenW:0]   rem_r;
  logic [QuoW-1:0] quo_r;
  logic [5:0]      dcnt_r;
  logic [DenW+1:0] trial;
  logic [DenW:0]   rem_sh;
  assign rem_sh = {rem_r[DenW-1:0], num_r[NumW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, den_r};

  // window sum
  logic [SumW-1:0] sum_r;
  logic [WinIdxW-1:0] sidx_r;
  logic [WinCntW-1:0] n_r;
  logic [QuoW-1:0] spd_sat;
  assign spd_sat = (quo_r > QuoW'(SpeedMax)) ? QuoW'(SpeedMax) : quo_r;

  assign sts.div_last = (dcnt_r == 6'd1);
  assign sts.avg_last = (dcnt_r == 6'd1);
  assign sts.sum_last = (WinCntW'(sidx_r) + WinCntW'(1) >= n_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_r  <= NumW'(dabs) * NumW'(RpmScale);
      den_r  <= DenW'(ppt_eff) * DenW'(dt);
    end else if (cmd.avg_init) begin
      // last sample is added in the same cycle
      num_r  <= {sum_r + SumW'(win_r[sidx_r]), {(NumW-SumW){1'b0}}};
      den_r  <= DenW'(n_r);
    end else if (cmd.div_step || cmd.avg_step) begin
      num_r  <= {num_r[NumW-2:0], 1'b0};
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      quo_r  <= '0;
      dcnt_r <= 6'(NumW);
    end else if (cmd.avg_init) begin
      rem_r  <= '0;
      quo_r  <= '0;
      dcnt_r <= 6'(SumW);
    end else if (cmd.div_step || cmd.avg_step) begin
      dcnt_r <= dcnt_r - 6'd1;
      if (!trial[DenW+1]) begin
        rem_r <= trial[DenW:0];
        quo_r <= {quo_r[QuoW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[QuoW-2:0], 1'b0};
      end
    end
  end

  // note: speed quotient can exceed QuoW bits; track overflow separately
  logic ovf_r;
  always_ff @(posedge clk) begin
    if (cmd.div_init) ovf_r <= 1'b0;
    else if (cmd.div_step && quo_r[QuoW-1]) ovf_r <= 1'b1;
  end

  logic [WinIdxW-1:0] slot_inc;
  logic               slot_wrap;
  assign slot_wrap = (slot_r >= WinIdxW'(WinDepth - 1));
  assign slot_inc  = slot_wrap ? '0 : slot_r + WinIdxW'(1);

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      sum_r  <= '0;
      sidx_r <= '0;
      n_r    <= (filled_r || slot_wrap) ? WinCntW'(WinDepth) : WinCntW'(slot_r) + WinCntW'(1);
    end else if (cmd.sum_step) begin
      sum_r  <= sum_r + SumW'(win_r[sidx_r]);
      sidx_r <= sidx_r + WinIdxW'(1);
    end
  end

  // regulation
  logic [17:0] err;
  logic        up;
  logic [6:0]  step_ivl;
  logic [5:0]  step;
  logic signed [11:0] duty_new;
  logic [9:0]  duty_cl;
  assign up   = (20'(target_r) > avg_r);
  assign err  = up ? 18'(20'(target_r) - avg_r) : 18'((avg_r - 20'(target_r)) > 20'h3FFFF
                ? 20'h3FFFF : avg_r - 20'(target_r));
  always_comb begin
    if (err > 18'd16000)      begin step_ivl = 7'd20;  step = 6'd40; end
    else if (err > 18'd8000)  begin step_ivl = 7'd25;  step = 6'd25; end
    else if (err > 18'd4000)  begin step_ivl = 7'd35;  step = 6'd15; end
    else if (err > {4'd0, fine_r, 4'd0}) begin step_ivl = 7'd50; step = 6'd5; end
    else                      begin step_ivl = 7'd125; step = 6'd1; end
    duty_new = up ? $signed({2'b0, duty_r}) + $signed(12'(step))
                  : $signed({2'b0, duty_r}) - $signed(12'(step));
    if (duty_new < 0)              duty_cl = '0;
    else if (duty_new > 12'sd1000) duty_cl = 10'd1000;
    else                           duty_cl = duty_new[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_meas_r <= '0; last_cnt_r <= '0; last_adj_r <= '0; settle_start_r <= '0;
      slot_r <= '0; filled_r <= 1'b0; avg_r <= '0; stable_r <= 1'b0;
      duty_r <= '0; pwm_r <= '0;
      for (int i = 0; i < WinDepth; i++) win_r[i] <= '0;
    end else begin
      if (cmd.do_start) begin
        duty_r <= 10'd500; pwm_r <= duty_to_pwm(10'd500);
        last_cnt_r <= cnt_r; last_meas_r <= now_r;
        settle_start_r <= now_r; last_adj_r <= now_r;
      end
      if (cmd.store) begin
        win_r[slot_r] <= ovf_r ? SpeedMax : spd_sat[19:0];
        slot_r <= slot_inc;
        if (slot_wrap) filled_r <= 1'b1;
        last_meas_r <= now_r; last_cnt_r <= cnt_r;
      end
      if (cmd.avg_done) avg_r <= trial[DenW+1] ? {quo_r[18:0], 1'b0} : {quo_r[18:0], 1'b1};
      if (cmd.regulate && !stable_r && (now_r - last_adj_r >= 32'(step_ivl))) begin
        last_adj_r <= now_r;
        if (err <= 18'(tol_r)) begin
          if (now_r - settle_start_r >= 32'(settle_r)) stable_r <= 1'b1;
        end else begin
          settle_start_r <= now_r;
          duty_r <= duty_cl;
          pwm_r  <= duty_to_pwm(duty_cl);
        end
      end
    end
  end

  assign pwm_level  = pwm_r;
  assign duty_level = duty_r;
  assign avg_speed  = avg_r;
  assign stable     = stable_r;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : self-checking bench for stepped_motor_speed_regulator
// Streams control and start beats, predicts each result beat with an
// independent integer model of the speed loop, checks field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import smsr_pkg::*;

  localparam bit ModeCtrl  = 1'b0;
  localparam bit ModeStart = 1'b1;
  localparam logic [2:0] RegUnmapped = 3'd7;
  localparam int IdleLimit = 200000;
  localparam int DrainWait = 200;

  typedef struct packed {
    logic        stable;
    logic [19:0] speed;
    logic [9:0]  duty;
    logic [7:0]  pwm;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;  // mode, now_ms, encoder_count (low bit up)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;      // pwm_duty, duty_tenths, measured_speed, is_stable
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [17:0] cfg_wdata = '0;

  stepped_motor_speed_regulator uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: registers
  logic [17:0] p_target;
  logic [9:0]  p_fine;
  logic [13:0] p_tol;
  logic [15:0] p_settle, p_ivl;
  logic [12:0] p_ppt;
  // predictor state: loop
  logic [31:0] p_meas_t, p_cnt, p_adj_t, p_settle_t;
  logic [19:0] p_win [WinDepth];
  int unsigned p_slot;
  logic        p_full, p_stable;
  logic [19:0] p_avg;
  logic [9:0]  p_duty;
  logic [7:0]  p_pwm;

  result_t expected_q[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      rx_hold = 1'b0;
  bit      rx_fast = 1'b0;
  logic [31:0] clock_ms = 0;
  logic [31:0] enc_pos = 0;

  function automatic logic [7:0] pct_to_pwm(input logic [9:0] t);
    return 8'(180 + ((t / 10) * 75) / 100);
  endfunction

  task automatic model_reset();
    p_target = 0; p_fine = 50; p_tol = 80; p_settle = 1000; p_ivl = 100; p_ppt = 12;
    p_meas_t = 0; p_cnt = 0; p_adj_t = 0; p_settle_t = 0;
    foreach (p_win[i]) p_win[i] = 0;
    p_slot = 0; p_full = 0; p_stable = 0; p_avg = 0; p_duty = 0; p_pwm = 0;
  endtask

  task automatic speed_update(input logic [31:0] now, input logic [31:0] cnt);
    logic [31:0] dt, d, ivl, ppt;
    logic [63:0] q, sum;
    int unsigned n;
    ivl = (p_ivl == 0) ? 1 : p_ivl;
    dt = now - p_meas_t;
    if (dt < ivl) return;
    d = cnt - p_cnt;
    if (d[31]) d = -d;
    ppt = (p_ppt == 0) ? 1 : p_ppt;
    q = (64'(d) * 64'd960000) / (64'(ppt) * 64'(dt));
    p_win[p_slot] = (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
    p_slot = (p_slot + 1) % WinDepth;
    if (p_slot == 0) p_full = 1;
    n = p_full ? WinDepth : p_slot;
    sum = 0;
    for (int i = 0; i < n; i++) sum += p_win[i];
    p_avg = 20'(sum / n);
    p_meas_t = now;
    p_cnt = cnt;
  endtask

  task automatic duty_update(input logic [31:0] now);
    longint diff, err, v;
    int unsigned ivl, stp;
    diff = longint'(p_target) - longint'(p_avg);
    err = diff < 0 ? -diff : diff;
    if (p_stable) return;
    if (err > 16000) begin ivl = 20; stp = 40; end
    else if (err > 8000) begin ivl = 25; stp = 25; end
    else if (err > 4000) begin ivl = 35; stp = 15; end
    else if (err > longint'(p_fine) * 16) begin ivl = 50; stp = 5; end
    else begin ivl = 125; stp = 1; end
    if (now - p_adj_t < ivl) return;
    p_adj_t = now;
    if (err <= p_tol) begin
      if (now - p_settle_t >= 32'(p_settle)) p_stable = 1;
    end else begin
      p_settle_t = now;
      v = longint'(p_duty) + (diff > 0 ? longint'(stp) : -longint'(stp));
      if (v < 0) v = 0;
      if (v > 1000) v = 1000;
      p_duty = 10'(v);
      p_pwm = pct_to_pwm(p_duty);
    end
  endtask

  // one beat through the predictor, then onto the input bus; tvalid is
  // dropped only across a gap, so back to back beats keep it high
  task automatic send_beat(input bit mode, input logic [31:0] now, input logic [31:0] cnt);
    result_t r;
    int gap;
    if (mode == ModeStart) begin
      p_duty = 500; p_pwm = pct_to_pwm(10'd500);
      p_cnt = cnt; p_meas_t = now; p_settle_t = now; p_adj_t = now;
    end else begin
      speed_update(now, cnt);
      duty_update(now);
    end
    r.pwm = p_pwm; r.duty = p_duty; r.speed = p_avg; r.stable = p_stable;
    expected_q.push_back(r);
    gap = rx_fast ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, cnt, now, mode};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
    case (idx)
      RegTarget:   p_target = val;
      RegFineLim:  p_fine = val[9:0];
      RegTol:      p_tol = val[13:0];
      RegSettle:   p_settle = val[15:0];
      RegInterval: p_ivl = val[15:0];
      RegPpt:      p_ppt = val[12:0];
      default: ;
    endcase
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DrainWait) @(posedge clk);
  endtask

  // motor-like sequence: time advances a few ms, encoder moves at some rate
  task automatic run_motion(input int beats, input int rate);
    for (int i = 0; i < beats; i++) begin
      int step = $urandom_range(1, 30);
      clock_ms += step;
      enc_pos += rate * step + $urandom_range(0, 4) - 2;
      send_beat(($urandom_range(0, 40) == 0) ? ModeStart : ModeCtrl, clock_ms, enc_pos);
    end
  endtask

  task automatic test_directed();
    send_beat(ModeCtrl, 32'd0, 32'd0);          // control before any start
    send_beat(ModeCtrl, 32'd150, 32'd600);
    send_beat(ModeStart, 32'd200, 32'd700);
    send_beat(ModeStart, 32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(ModeCtrl, 32'h0000_0100, 32'h7FFF_FFFF); // wrapped time, huge count
    send_beat(ModeCtrl, 32'h0000_0200, 32'h8000_0000); // count crosses the signed boundary by one
    send_beat(ModeCtrl, 32'h0000_0202, 32'h8000_0001);
    send_beat(ModeCtrl, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    write_reg(RegPpt, 18'd0);                   // zero pulses treated as one
    write_reg(RegInterval, 18'd0);              // zero interval treated as one
    write_reg(RegTarget, 18'h3FFFF);
    write_reg(RegFineLim, 18'h3FF);
    write_reg(RegTol, 18'h3FFF);
    write_reg(RegSettle, 18'd0);
    write_reg(RegUnmapped, 18'h3FFFF);          // unmapped index ignored
    clock_ms = 32'd1000; enc_pos = 0;
    send_beat(ModeStart, clock_ms, enc_pos);
    for (int i = 0; i < 10; i++) begin
      clock_ms += 1 + i * 40; enc_pos += 1000 * i;
      send_beat(ModeCtrl, clock_ms, enc_pos);
    end
    drain();
  endtask

  task automatic test_regulation(input logic [17:0] tgt, input logic [9:0] fine,
                                 input logic [13:0] tol, input logic [15:0] settle,
                                 input logic [15:0] ivl, input logic [12:0] ppt,
                                 input int beats);
    write_reg(RegTarget, tgt);
    write_reg(RegFineLim, 18'(fine));
    write_reg(RegTol, 18'(tol));
    write_reg(RegSettle, 18'(settle));
    write_reg(RegInterval, 18'(ivl));
    write_reg(RegPpt, 18'(ppt));
    clock_ms += 5;
    send_beat(ModeStart, clock_ms, enc_pos);
    run_motion(beats, int'($urandom_range(0, 60)));
    drain();
  endtask

  task automatic test_noise(input int beats);
    for (int i = 0; i < beats; i++)
      send_beat(1'($urandom), $urandom, $urandom);
    drain();
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
      run_motion(12, 20);
    join
    drain();
    rx_fast = 1'b1;                             // no idling on either side
    run_motion(20, 35);
    rx_fast = 1'b0;
    drain();                                    // sender waits for every result
  endtask

  // receiver: random stall per beat, held off entirely while rx_hold
  initial begin
    int stall;
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, 16);
      if (stall > 0 || rx_hold) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_t got, exp_r;
      got = out_tdata[38:0];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.pwm !== exp_r.pwm || got.duty !== exp_r.duty ||
            got.speed !== exp_r.speed || got.stable !== exp_r.stable) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pwm %0d/%0d duty %0d/%0d speed %0d/%0d stable %0d/%0d",
                     exp_r.pwm, got.pwm, exp_r.duty, got.duty,
                     exp_r.speed, got.speed, exp_r.stable, got.stable);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_regulation(18'd2000, 10'd50, 14'd80, 16'd100, 16'd50, 13'd12, 60);
    test_regulation(18'd0, 10'd0, 14'd0, 16'd0, 16'd1, 13'd1, 40);
    test_regulation(18'd160000, 10'd1000, 14'd16000, 16'd65535, 16'd65535, 13'd4096, 20);
    test_regulation(18'd12000, 10'd10, 14'd500, 16'd20, 16'd10, 13'd24, 80);
    test_regulation(18'd30000, 10'd100, 14'd16000, 16'd0, 16'd30, 13'd6, 60);
    test_backpressure();
    test_noise(40);
    test_regulation(18'd6000, 10'd200, 14'd2000, 16'd50, 16'd20, 13'd12, 80);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
